FILE: rtl/evad_pkg.sv
// evad_pkg: shared types and constants of the energy voice activity detector
// used by evad_ctrl, evad_dp and energy_voice_activity_detector_top
`default_nettype none

package evad_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int SQ_W      = 31;
	localparam int MEAN_W    = 31;
	localparam int ENERGY_W  = 16;
	localparam int FLOOR_W   = 25;
	localparam int NOISE_W   = 16;
	localparam int THR_W     = 16;
	localparam int GAIN_W    = 12;
	localparam int RUN_W     = 8;
	localparam int ACT_W     = 19;
	localparam int PROD_W    = FLOOR_W + GAIN_W;
	localparam int ADAPT_W   = PROD_W - 16;
	localparam int ROOT_STEPS = ENERGY_W;
	localparam int SREM_W    = 17;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_GAIN      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_REQUIRED  = 2'd2;

	localparam logic [THR_W-1:0]  THR_RESET    = 16'd500;
	localparam logic [GAIN_W-1:0] GAIN_RESET   = 12'd512;
	localparam logic [RUN_W-1:0]  FRAMES_RESET = 8'd3;

	localparam logic [RUN_W-1:0] RUN_MAX    = 8'd255;
	localparam int               BLEND_OLD  = 3;
	localparam int               DRIFT_OLD  = 243;
	localparam int               DRIFT_NEW  = 13;

	typedef struct packed {
		logic div_step;
		logic root_load;
		logic root_step;
		logic floor_seed;
		logic gain_mul;
		logic decide;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic start;
		logic seed_or_grace;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/evad_ctrl.sv
// evad_ctrl: frame-end sequencer for division, square root, floor or run update and result load
// depends on evad_pkg (cmd_t, status_t, ROOT_STEPS)
`default_nettype none

module evad_ctrl #(
	parameter int SUM_W = 41
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire evad_pkg::status_t st,
	output evad_pkg::cmd_t        cmd,
	output logic                  busy
);

	localparam int STEP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ROOT_LOAD,
		ST_ROOT,
		ST_SEED,
		ST_MUL,
		ST_DECIDE,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              seed_path_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			seed_path_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (st.start) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (step_q == STEP_W'(SUM_W - 1)) begin
						step_q  <= '0;
						state_q <= ST_ROOT_LOAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ROOT_LOAD: begin
					step_q  <= '0;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (step_q == STEP_W'(evad_pkg::ROOT_STEPS - 1)) begin
						step_q      <= '0;
						seed_path_q <= st.seed_or_grace;
						state_q     <= st.seed_or_grace ? ST_SEED : ST_MUL;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SEED:   state_q <= ST_MUL;
				ST_MUL:    state_q <= seed_path_q ? ST_EMIT : ST_DECIDE;
				ST_DECIDE: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (st.out_free) state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd            = '0;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.root_load  = (state_q == ST_ROOT_LOAD);
		cmd.root_step  = (state_q == ST_ROOT);
		cmd.floor_seed = (state_q == ST_SEED);
		cmd.gain_mul   = (state_q == ST_MUL);
		cmd.decide     = (state_q == ST_DECIDE);
		cmd.load_out   = (state_q == ST_EMIT) && st.out_free;
	end

	assign busy = (state_q != ST_IDLE);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		st.start |-> state_q == ST_IDLE)
		else $error("frame start while sequencer busy");

	a_div_to_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == STEP_W'(SUM_W - 1)) |=> state_q == ST_ROOT_LOAD)
		else $error("division did not hand over to square root");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> state_q == ST_IDLE)
		else $error("sequencer not idle after result load");

endmodule

`default_nettype wire

FILE: rtl/evad_dp.sv
// evad_dp: square accumulator, shift-subtract divider, digit square root,
// noise floor and run logic, result register; depends on evad_pkg
`default_nettype none

module evad_dp #(
	parameter int MAX_FRAME = 1024,
	parameter int CNT_W     = 11,
	parameter int SUM_W     = 41
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_take,
	input  wire logic signed [evad_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  frame_end,
	input  wire logic                                  in_grace,
	input  wire logic                                  cfg_we,
	input  wire logic [evad_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [evad_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  wire evad_pkg::cmd_t                        cmd,
	output evad_pkg::status_t                          st,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic [evad_pkg::ENERGY_W-1:0]              frame_energy,
	output logic [evad_pkg::NOISE_W-1:0]               noise_floor,
	output logic [evad_pkg::ACT_W-1:0]                 active_threshold,
	output logic [evad_pkg::RUN_W-1:0]                 run_length,
	output logic                                       speech_detected
);

	localparam int ROOT_RAD_W = 2 * evad_pkg::ROOT_STEPS;
	localparam int BLEND_W    = evad_pkg::FLOOR_W + 2;
	localparam int DRIFT_W    = evad_pkg::FLOOR_W + 9;

	// configuration
	logic [evad_pkg::THR_W-1:0]  thr_q;
	logic [evad_pkg::GAIN_W-1:0] gain_q;
	logic [evad_pkg::RUN_W-1:0]  frames_q;

	// accumulator
	logic [SUM_W-1:0] acc_sum_q;
	logic [CNT_W-1:0] acc_cnt_q;
	logic             grace_q;

	// divider
	logic [SUM_W-1:0] quo_q;
	logic [CNT_W-1:0] den_q;
	logic [CNT_W-1:0] rem_q;

	// square root
	logic [ROOT_RAD_W-1:0]          rad_q;
	logic [evad_pkg::ENERGY_W-1:0]  root_q;
	logic [evad_pkg::SREM_W-1:0]    srem_q;

	// floor and run
	logic [evad_pkg::FLOOR_W-1:0] floor_q;
	logic                         floor_valid_q;
	logic [evad_pkg::PROD_W-1:0]  gain_prod_q;
	logic [evad_pkg::RUN_W-1:0]   run_q;
	logic                         speech_q;
	logic                         out_valid_q;

	logic signed [2*evad_pkg::SAMPLE_W-1:0] sq_full;
	logic [evad_pkg::SQ_W-1:0]              sq;
	logic                                   frame_full;
	logic [SUM_W-1:0]                       sum_next;
	logic [CNT_W-1:0]                       cnt_next;
	logic [CNT_W:0]                         div_trial;
	logic                                   div_bit;
	logic [evad_pkg::SREM_W+1:0]            root_trial;
	logic [evad_pkg::SREM_W+1:0]            root_try;
	logic                                   root_bit;
	logic [evad_pkg::FLOOR_W-1:0]           e8;
	logic [BLEND_W-1:0]                     blend;
	logic [DRIFT_W-1:0]                     drift;
	logic [evad_pkg::ADAPT_W-1:0]           adaptive;
	logic [evad_pkg::ADAPT_W-1:0]           thr_now;
	logic                                   loud;
	logic [evad_pkg::RUN_W-1:0]             run_inc;

	always_comb begin
		sq_full    = sample * sample;
		sq         = sq_full[evad_pkg::SQ_W-1:0];
		frame_full = (acc_cnt_q >= CNT_W'(MAX_FRAME));
		sum_next   = frame_full ? acc_sum_q : acc_sum_q + SUM_W'(sq);
		cnt_next   = frame_full ? acc_cnt_q : acc_cnt_q + 1'b1;

		div_trial  = {rem_q, quo_q[SUM_W-1]};
		div_bit    = (div_trial >= {1'b0, den_q});

		root_trial = {srem_q, rad_q[ROOT_RAD_W-1 -: 2]};
		root_try   = {1'b0, root_q, 2'b01};
		root_bit   = (root_trial >= root_try);

		e8         = evad_pkg::FLOOR_W'({root_q, 8'b0});
		blend      = BLEND_W'(floor_q) * BLEND_W'(evad_pkg::BLEND_OLD) + BLEND_W'(e8);
		drift      = DRIFT_W'(floor_q) * DRIFT_W'(evad_pkg::DRIFT_OLD)
		           + DRIFT_W'(e8) * DRIFT_W'(evad_pkg::DRIFT_NEW);

		adaptive   = gain_prod_q[evad_pkg::PROD_W-1:16];
		thr_now    = (adaptive > evad_pkg::ADAPT_W'(thr_q)) ? adaptive
		                                                   : evad_pkg::ADAPT_W'(thr_q);
		loud       = (evad_pkg::ADAPT_W'(root_q) >= thr_now);
		run_inc    = (run_q != evad_pkg::RUN_MAX) ? run_q + 1'b1 : run_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q         <= evad_pkg::THR_RESET;
			gain_q        <= evad_pkg::GAIN_RESET;
			frames_q      <= evad_pkg::FRAMES_RESET;
			acc_sum_q     <= '0;
			acc_cnt_q     <= '0;
			floor_q       <= '0;
			floor_valid_q <= 1'b0;
			run_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					evad_pkg::CFG_ENERGY_THRESHOLD: thr_q    <= cfg_data[evad_pkg::THR_W-1:0];
					evad_pkg::CFG_MARGIN_GAIN:      gain_q   <= cfg_data[evad_pkg::GAIN_W-1:0];
					evad_pkg::CFG_FRAMES_REQUIRED:  frames_q <= cfg_data[evad_pkg::RUN_W-1:0];
					default: ;
				endcase
			end
			if (in_take) begin
				if (frame_end) begin
					acc_sum_q <= '0;
					acc_cnt_q <= '0;
				end else begin
					acc_sum_q <= sum_next;
					acc_cnt_q <= cnt_next;
				end
			end
			if (cmd.floor_seed) begin
				floor_valid_q <= 1'b1;
				floor_q <= floor_valid_q ? blend[BLEND_W-1:2] : e8;
			end
			if (cmd.decide) begin
				if (loud) begin
					run_q <= run_inc;
				end else begin
					run_q   <= '0;
					floor_q <= drift[evad_pkg::FLOOR_W+7:8];
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take && frame_end) begin
			quo_q   <= sum_next;
			den_q   <= (cnt_next == '0) ? CNT_W'(1) : cnt_next;
			rem_q   <= '0;
			grace_q <= in_grace;
		end else if (cmd.div_step) begin
			rem_q <= div_bit ? CNT_W'(div_trial - {1'b0, den_q}) : div_trial[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], div_bit};
		end
		if (cmd.root_load) begin
			rad_q  <= ROOT_RAD_W'(quo_q[evad_pkg::MEAN_W-1:0]);
			root_q <= '0;
			srem_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[ROOT_RAD_W-3:0], 2'b00};
			root_q <= {root_q[evad_pkg::ENERGY_W-2:0], root_bit};
			srem_q <= root_bit ? evad_pkg::SREM_W'(root_trial - root_try)
			                   : root_trial[evad_pkg::SREM_W-1:0];
		end
		if (cmd.gain_mul) begin
			gain_prod_q <= evad_pkg::PROD_W'(floor_q) * evad_pkg::PROD_W'(gain_q);
		end
		if (cmd.floor_seed) begin
			speech_q <= 1'b0;
		end else if (cmd.decide) begin
			speech_q <= loud && (run_inc >= frames_q);
		end
		if (cmd.load_out) begin
			frame_energy     <= root_q;
			noise_floor      <= floor_q[evad_pkg::NOISE_W+7:8];
			active_threshold <= thr_now[evad_pkg::ACT_W-1:0];
			run_length       <= run_q;
			speech_detected  <= speech_q;
		end
	end

	assign st.start         = in_take && frame_end;
	assign st.seed_or_grace = grace_q || !floor_valid_q;
	assign st.out_free      = !out_valid_q || !out_stall;
	assign out_valid        = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(out_valid_q && out_stall))
		else $error("result register overwritten while stalled");

	a_seed_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.floor_seed |=> floor_valid_q)
		else $error("floor not marked valid after seed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		acc_cnt_q <= CNT_W'(MAX_FRAME))
		else $error("sample count beyond frame limit");

endmodule

`default_nettype wire

FILE: rtl/energy_voice_activity_detector_top.sv
// energy_voice_activity_detector_top: energy voice activity detector
// depends on evad_pkg, evad_ctrl, evad_dp
//
// Input channel (in_valid / in_stall): one signed sample per transaction,
// frame_end marks the last sample of a frame, in_grace is sampled with it.
// Samples are taken one per cycle unless in_stall holds a frame_end sample.
// At a frame end the sum and count are captured and the accumulator
// restarts, so the next frame keeps flowing. Frame processing: shift-subtract
// division, a load step, digit square root, then floor seed or run update
// with the gain multiply, then the result load, which raises out_valid.
// The divider and square root unit serve one frame at a time: a sample with
// frame_end that arrives while the previous frame is still in process sees
// in_stall high until the sequencer is free; other samples are not held.
// Output channel (out_valid / out_stall): one result per frame; it waits in
// the result register while out_stall is high and blocks the next result.
// Configuration (cfg_valid / cfg_ready): always ready, write while idle.
// Reset clears the accumulator, noise floor, run count and output valid and
// loads the configuration defaults.
`default_nettype none

module energy_voice_activity_detector_top #(
	parameter int MAX_FRAME = 1024
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic signed [evad_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  frame_end,
	input  wire logic                                  in_grace,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic [evad_pkg::ENERGY_W-1:0]              frame_energy,
	output logic [evad_pkg::NOISE_W-1:0]               noise_floor,
	output logic [evad_pkg::ACT_W-1:0]                 active_threshold,
	output logic [evad_pkg::RUN_W-1:0]                 run_length,
	output logic                                       speech_detected,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [evad_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [evad_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int SUM_W = evad_pkg::SQ_W - 1 + CNT_W;

	evad_pkg::cmd_t    cmd;
	evad_pkg::status_t st;
	logic              busy;
	logic              in_take;

	assign in_stall  = busy && frame_end;
	assign in_take   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	evad_ctrl #(
		.SUM_W (SUM_W)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.cmd    (cmd),
		.busy   (busy)
	);

	evad_dp #(
		.MAX_FRAME (MAX_FRAME),
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_take          (in_take),
		.sample           (sample),
		.frame_end        (frame_end),
		.in_grace         (in_grace),
		.cfg_we           (cfg_valid && cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.cmd              (cmd),
		.st               (st),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.frame_energy     (frame_energy),
		.noise_floor      (noise_floor),
		.active_threshold (active_threshold),
		.run_length       (run_length),
		.speech_detected  (speech_detected)
	);

endmodule

`default_nettype wire

FILE: test/energy_voice_activity_detector_top_test.sv
`timescale 1ns / 1ps
// energy_voice_activity_detector_top_test: self-checking bench for the energy voice activity
// detector; a scoreboard predicts each frame result from the accepted samples
// depends on evad_pkg and energy_voice_activity_detector_top
module energy_voice_activity_detector_top_test;

	localparam int FRAME_CAP     = 1024;
	localparam int ITEM_GOAL     = 950;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [evad_pkg::ENERGY_W-1:0] energy;
		logic [evad_pkg::NOISE_W-1:0]  noise;
		logic [evad_pkg::ACT_W-1:0]    threshold;
		logic [evad_pkg::RUN_W-1:0]    run;
		logic                          speech;
	} vad_frame_t;

	typedef enum int {FRAME_QUIET, FRAME_LOUD, FRAME_WILD} frame_kind_t;

	class vad_frame_scoreboard;
		vad_frame_t                  expected_frames[$];
		logic [evad_pkg::THR_W-1:0]  thr_reg;
		logic [evad_pkg::GAIN_W-1:0] gain_reg;
		logic [evad_pkg::RUN_W-1:0]  need_reg;
		longint unsigned             square_acc;
		int unsigned                 sample_cnt;
		longint unsigned             floor_q8;
		bit                          floor_seeded;
		int unsigned                 loud_count;
		int unsigned                 mismatches;
		int unsigned                 frames_seen;
		int unsigned                 speech_frames;
		int unsigned                 longest_run;

		function new();
			thr_reg = evad_pkg::THR_RESET;
			gain_reg = evad_pkg::GAIN_RESET;
			need_reg = evad_pkg::FRAMES_RESET;
			square_acc = 0;
			sample_cnt = 0;
			floor_q8 = 0;
			floor_seeded = 0;
			loud_count = 0;
			mismatches = 0;
			frames_seen = 0;
			speech_frames = 0;
			longest_run = 0;
		endfunction

		function void write_register(logic [evad_pkg::CFG_IDX_W-1:0] idx,
			logic [evad_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				evad_pkg::CFG_ENERGY_THRESHOLD: thr_reg = data[evad_pkg::THR_W-1:0];
				evad_pkg::CFG_MARGIN_GAIN:      gain_reg = data[evad_pkg::GAIN_W-1:0];
				evad_pkg::CFG_FRAMES_REQUIRED:  need_reg = data[evad_pkg::RUN_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int i = 15; i >= 0; i--) begin
				t = r | (64'd1 << i);
				if (t * t <= v)
					r = t;
			end
			return int'(r);
		endfunction

		function int unsigned threshold_now();
			longint unsigned adapt;
			adapt = (floor_q8 * gain_reg) >> 16;
			return (adapt > thr_reg) ? int'(adapt) : int'(thr_reg);
		endfunction

		function void note_sample(logic signed [evad_pkg::SAMPLE_W-1:0] s, bit last, bit grace);
			vad_frame_t      r;
			longint unsigned e8;
			int unsigned     energy;
			int unsigned     thr;
			bit              spoke;
			spoke = 0;
			if (sample_cnt < FRAME_CAP) begin
				square_acc += longint'(s) * longint'(s);
				sample_cnt++;
			end
			if (!last)
				return;
			energy = root_floor(square_acc / sample_cnt);
			square_acc = 0;
			sample_cnt = 0;
			e8 = longint'(energy) << 8;
			if (grace || !floor_seeded) begin
				floor_q8 = floor_seeded ? (3 * floor_q8 + e8) >> 2 : e8;
				floor_seeded = 1;
				thr = threshold_now();
			end else begin
				thr = threshold_now();
				if (energy >= thr) begin
					if (loud_count < evad_pkg::RUN_MAX)
						loud_count++;
					spoke = loud_count >= need_reg;
				end else begin
					loud_count = 0;
					floor_q8 = (243 * floor_q8 + 13 * e8) >> 8;
				end
			end
			r.energy = energy[evad_pkg::ENERGY_W-1:0];
			r.noise = floor_q8[evad_pkg::NOISE_W+7:8];
			r.threshold = thr[evad_pkg::ACT_W-1:0];
			r.run = loud_count[evad_pkg::RUN_W-1:0];
			r.speech = spoke;
			if (spoke)
				speech_frames++;
			if (loud_count > longest_run)
				longest_run = loud_count;
			expected_frames.push_back(r);
		endfunction

		function void compare_field(string name, logic [evad_pkg::ACT_W-1:0] want,
			logic [evad_pkg::ACT_W-1:0] got);
			if (got !== want) begin
				$display("%0t: frame %0d %s expected %0d got %0d", $time, frames_seen, name,
					want, got);
				mismatches++;
			end
		endfunction

		function void check_frame(vad_frame_t got);
			vad_frame_t want;
			if (expected_frames.size() == 0) begin
				$display("%0t: result with no frame pending, expected none got energy %0d",
					$time, got.energy);
				mismatches++;
				return;
			end
			want = expected_frames.pop_front();
			compare_field("frame_energy", evad_pkg::ACT_W'(want.energy),
				evad_pkg::ACT_W'(got.energy));
			compare_field("noise_floor", evad_pkg::ACT_W'(want.noise),
				evad_pkg::ACT_W'(got.noise));
			compare_field("active_threshold", want.threshold, got.threshold);
			compare_field("run_length", evad_pkg::ACT_W'(want.run), evad_pkg::ACT_W'(got.run));
			compare_field("speech_detected", evad_pkg::ACT_W'(want.speech),
				evad_pkg::ACT_W'(got.speech));
			frames_seen++;
		endfunction

		function int pending();
			return expected_frames.size();
		endfunction
	endclass

	logic                                   clk = 1'b0;
	logic                                   arst_n = 1'b0;
	logic                                   in_valid = 1'b0;
	logic                                   in_stall;
	logic signed [evad_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                                   frame_end = 1'b0;
	logic                                   in_grace = 1'b0;
	logic                                   out_valid;
	logic                                   out_stall = 1'b0;
	logic [evad_pkg::ENERGY_W-1:0]          frame_energy;
	logic [evad_pkg::NOISE_W-1:0]           noise_floor;
	logic [evad_pkg::ACT_W-1:0]             active_threshold;
	logic [evad_pkg::RUN_W-1:0]             run_length;
	logic                                   speech_detected;
	logic                                   cfg_valid = 1'b0;
	logic                                   cfg_ready;
	logic [evad_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
	logic [evad_pkg::CFG_DATA_W-1:0]        cfg_data = '0;

	vad_frame_scoreboard sb = new();
	bit idle_enable = 1'b1;
	bit stall_enable = 1'b1;
	int items_sent = 0;

	energy_voice_activity_detector_top #(.MAX_FRAME(FRAME_CAP)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample(sample),
		.frame_end(frame_end),
		.in_grace(in_grace),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_energy(frame_energy),
		.noise_floor(noise_floor),
		.active_threshold(active_threshold),
		.run_length(run_length),
		.speech_detected(speech_detected),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// result side: check accepted transactions, then pick next stall
	always @(posedge clk) begin
		vad_frame_t got;
		if (arst_n && out_valid && !out_stall) begin
			got.energy = frame_energy;
			got.noise = noise_floor;
			got.threshold = active_threshold;
			got.run = run_length;
			got.speech = speech_detected;
			sb.check_frame(got);
		end
		out_stall <= stall_enable && ($urandom_range(99) < 28);
	end

	task automatic send_sample(input logic signed [evad_pkg::SAMPLE_W-1:0] s, input bit last,
		input bit grace);
		if (idle_enable && $urandom_range(99) < 28) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		frame_end <= last;
		in_grace <= grace;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s, last, grace);
		items_sent++;
	endtask

	task automatic send_frame(input int len, input int amp, input bit grace);
		logic signed [evad_pkg::SAMPLE_W-1:0] s;
		int v;
		for (int k = 0; k < len; k++) begin
			if (amp > 32767)
				s = 16'($urandom);
			else begin
				v = int'($urandom_range(2 * amp)) - amp;
				s = v[evad_pkg::SAMPLE_W-1:0];
			end
			send_sample(s, k == len - 1, (k == len - 1) ? grace : 1'($urandom_range(1)));
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_registers(input logic [evad_pkg::CFG_DATA_W-1:0] thr,
		input logic [evad_pkg::CFG_DATA_W-1:0] gain,
		input logic [evad_pkg::CFG_DATA_W-1:0] need);
		logic [evad_pkg::CFG_IDX_W-1:0]  idx [3];
		logic [evad_pkg::CFG_DATA_W-1:0] val [3];
		idx = '{evad_pkg::CFG_ENERGY_THRESHOLD, evad_pkg::CFG_MARGIN_GAIN,
			evad_pkg::CFG_FRAMES_REQUIRED};
		val = '{thr, gain, need};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_register(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int phase;
		int phase_end;
		int amp;
		frame_kind_t kind;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: seed, ordinary, grace and quiet frames
		send_sample(-16'sd32768, 1'b1, 1'b0);
		send_sample(16'sd32767, 1'b0, 1'b0);
		send_sample(16'sd0, 1'b0, 1'b1);
		send_sample(-16'sd1, 1'b1, 1'b0);
		send_sample(16'sd1, 1'b1, 1'b1);
		send_sample(16'sd100, 1'b0, 1'b1);
		send_sample(-16'sd100, 1'b1, 1'b0);
		repeat (4) send_sample(16'sd0, 1'b0, 1'b0);
		send_sample(16'sd0, 1'b1, 1'b0);
		repeat (3) send_sample(16'sd32767, 1'b1, 1'b0);
		settle();

		// everything loud, zero required frames, run saturation
		program_registers(16'd0, 16'd0, 16'd0);
		send_sample(16'sd0, 1'b1, 1'b0);
		send_sample(-16'sd32768, 1'b1, 1'b0);
		idle_enable = 1'b0;
		stall_enable = 1'b0;
		repeat (262) send_frame(1, 32768, 1'b0);
		idle_enable = 1'b1;
		stall_enable = 1'b1;
		settle();

		// upper extremes and out-of-range register bits
		program_registers(16'hffff, 16'hffff, 16'hffff);
		repeat (6) send_frame($urandom_range(1, 4), 32768, $urandom_range(99) < 20);
		settle();
		program_registers(16'd0, 16'd4095, 16'd255);
		repeat (6) send_frame($urandom_range(1, 4), 32768, $urandom_range(99) < 20);

		// random frames in bursts of like loudness
		phase = 0;
		while (items_sent < ITEM_GOAL) begin
			settle();
			program_registers(($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(3000)),
				($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(64, 768)),
				($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
			idle_enable = (phase != 1);
			stall_enable = (phase != 1);
			phase_end = items_sent + 120;
			while (items_sent < phase_end && items_sent < ITEM_GOAL) begin
				kind = frame_kind_t'($urandom_range(2));
				repeat ($urandom_range(1, 6)) begin
					case (kind)
						FRAME_QUIET: amp = $urandom_range(200);
						FRAME_LOUD:  amp = $urandom_range(2000, 32767);
						default:     amp = 32768;
					endcase
					send_frame($urandom_range(1, 24), amp, $urandom_range(99) < 10);
				end
			end
			phase++;
		end
		idle_enable = 1'b1;
		stall_enable = 1'b1;
		settle();

		$display("sent %0d samples over %0d register phases, checked %0d frames",
			items_sent, phase + 3, sb.frames_seen);
		$display("%0d frames reported speech, longest loud run %0d, %0d mismatches",
			sb.speech_frames, sb.longest_run, sb.mismatches);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5000000;
		$display("timeout with %0d frames outstanding", sb.pending());
		$display("TB_ERROR");
		$finish;
	end

endmodule
